### rtl/core/pearson_correlation_macros.svh
// Assertion macros for the Pearson correlation block and its checker.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef PEARSON_CORRELATION_MACROS_SVH
`define PEARSON_CORRELATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCORR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCORR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pcorr_pkg.sv
// Shared constants, types and the arithmetic micro-program of the Pearson correlation block.
// Used by pearson_correlation, pcorr_root and pcorr_checker; depends on nothing.
`default_nettype none

package pcorr_pkg;

    localparam int MAX_LEN     = 256;
    localparam int SAMPLE_BITS = 16;

    localparam logic [15:0] SAMPLE_MASK =
        (SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((1 << SAMPLE_BITS) - 1);
    localparam logic [8:0]  MAX_CNT     = 9'(MAX_LEN);

    // Widths of the final arithmetic.
    localparam int LIMB_W = 25;
    localparam int MAG_W  = 49;
    localparam int PROD_W = 2 * LIMB_W;
    localparam int ACC_W  = 100;
    localparam int WIDE_W = 98;
    localparam int QUO_W  = 33;
    localparam int ROOT_W = 17;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [4:0] {
        OPD_A, OPD_B, OPD_N, OPD_SA, OPD_SB,
        OPD_SAA_L, OPD_SAA_H, OPD_SBB_L, OPD_SBB_H, OPD_SAB_L, OPD_SAB_H,
        OPD_VA_L, OPD_VA_H, OPD_VB_L, OPD_VB_H, OPD_CM_L, OPD_CM_H
    } t_opnd;

    typedef enum logic [1:0] {
        DST_SAA, DST_SBB, DST_SAB, DST_ACC
    } t_dst;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_VA, CAP_VB, CAP_CV, CAP_P, CAP_C2
    } t_cap;

    typedef struct packed {
        t_opnd      x;
        t_opnd      y;
        logic [1:0] sh;
        logic       sub;
        logic       clr;
        t_dst       dst;
        t_cap       cap;
    } t_uop;

    localparam logic [4:0] STEP_PAIR_FIRST  = 5'd0;
    localparam logic [4:0] STEP_PAIR_LAST   = 5'd2;
    localparam logic [4:0] STEP_FINAL_FIRST = 5'd3;
    localparam logic [4:0] STEP_FINAL_LAST  = 5'd19;

    // One multiply-accumulate per step. The shift counts whole limbs.
    function automatic t_uop f_uop(input logic [4:0] idx);
        t_uop u;
        u = '{x: OPD_A, y: OPD_A, sh: 2'd0, sub: 1'b0, clr: 1'b0,
              dst: DST_ACC, cap: CAP_NONE};
        case (idx)
            5'd0:  begin u.x = OPD_A; u.y = OPD_A; u.dst = DST_SAA; end
            5'd1:  begin u.x = OPD_B; u.y = OPD_B; u.dst = DST_SBB; end
            5'd2:  begin u.x = OPD_A; u.y = OPD_B; u.dst = DST_SAB; end
            5'd3:  begin u.x = OPD_N; u.y = OPD_SAA_L; u.clr = 1'b1; end
            5'd4:  begin u.x = OPD_N; u.y = OPD_SAA_H; u.sh = 2'd1; end
            5'd5:  begin u.x = OPD_SA; u.y = OPD_SA; u.sub = 1'b1; u.cap = CAP_VA; end
            5'd6:  begin u.x = OPD_N; u.y = OPD_SBB_L; u.clr = 1'b1; end
            5'd7:  begin u.x = OPD_N; u.y = OPD_SBB_H; u.sh = 2'd1; end
            5'd8:  begin u.x = OPD_SB; u.y = OPD_SB; u.sub = 1'b1; u.cap = CAP_VB; end
            5'd9:  begin u.x = OPD_N; u.y = OPD_SAB_L; u.clr = 1'b1; end
            5'd10: begin u.x = OPD_N; u.y = OPD_SAB_H; u.sh = 2'd1; end
            5'd11: begin u.x = OPD_SA; u.y = OPD_SB; u.sub = 1'b1; u.cap = CAP_CV; end
            5'd12: begin u.x = OPD_VA_L; u.y = OPD_VB_L; u.clr = 1'b1; end
            5'd13: begin u.x = OPD_VA_L; u.y = OPD_VB_H; u.sh = 2'd1; end
            5'd14: begin u.x = OPD_VA_H; u.y = OPD_VB_L; u.sh = 2'd1; end
            5'd15: begin u.x = OPD_VA_H; u.y = OPD_VB_H; u.sh = 2'd2; u.cap = CAP_P; end
            5'd16: begin u.x = OPD_CM_L; u.y = OPD_CM_L; u.clr = 1'b1; end
            5'd17: begin u.x = OPD_CM_L; u.y = OPD_CM_H; u.sh = 2'd1; end
            5'd18: begin u.x = OPD_CM_H; u.y = OPD_CM_L; u.sh = 2'd1; end
            5'd19: begin u.x = OPD_CM_H; u.y = OPD_CM_H; u.sh = 2'd2; u.cap = CAP_C2; end
            default: ;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pcorr_root.sv
// Shift-and-subtract unit: the quotient floor(c2 * 2^32 / p), then its integer square root.
// Depends on pcorr_pkg for widths.
`default_nettype none

module pcorr_root import pcorr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WIDE_W-1:0]   i_p,
    input  logic [WIDE_W-1:0]   i_c2,
    output logic                o_done,
    output logic [ROOT_W-1:0]   o_root
);

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_DIV  = 3'b010,
        R_SQRT = 3'b100
    } t_root_state;

    t_root_state       r_state;
    logic [5:0]        r_cnt;
    logic              r_lsb;
    logic              r_done;
    logic [WIDE_W:0]   r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [QUO_W:0]    r_dsh;
    logic [ROOT_W-1:0] r_root;

    logic [WIDE_W:0]   sh_rem;
    logic [WIDE_W:0]   trial;
    logic [WIDE_W+1:0] diff;
    logic              ge;
    logic              div_bit;
    logic [QUO_W-1:0]  n_quo;

    // The dividend is c2 followed by 32 zero bits; its lowest bit of c2 enters first.
    assign div_bit = (r_cnt == 6'd0) ? r_lsb : 1'b0;

    always_comb begin
        if (r_state == R_DIV) begin
            sh_rem = {r_rem[WIDE_W-1:0], div_bit};
            trial  = {1'b0, i_p};
        end else begin
            sh_rem = {r_rem[WIDE_W-2:0], r_dsh[QUO_W:QUO_W-1]};
            trial  = {{(WIDE_W - ROOT_W - 1){1'b0}}, r_root, 2'b01};
        end
        diff  = {1'b0, sh_rem} - {1'b0, trial};
        ge    = ~diff[WIDE_W+1];
        n_quo = {r_quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_rem   <= {2'b00, i_c2[WIDE_W-1:1]};
                        r_lsb   <= i_c2[0];
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= R_DIV;
                    end
                end
                R_DIV: begin
                    r_rem <= ge ? diff[WIDE_W:0] : sh_rem;
                    r_quo <= n_quo;
                    if (r_cnt == 6'(QUO_W - 1)) begin
                        r_dsh   <= {1'b0, n_quo};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= R_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                R_SQRT: begin
                    r_rem  <= ge ? diff[WIDE_W:0] : sh_rem;
                    r_root <= {r_root[ROOT_W-2:0], ge};
                    r_dsh  <= {r_dsh[QUO_W-2:0], 2'b00};
                    if (r_cnt == 6'(ROOT_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= R_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

### rtl/core/pearson_correlation.sv
// Top level of the Pearson correlation block: accumulators, multiply sequencer, result register.
// Depends on pcorr_pkg and pcorr_root.
`default_nettype none

// Streams sample pairs in and returns, for the pair marked last, the correlation coefficient
// in signed Q1.15 with a status code (0 ok, 1 zero variance, 2 more than 256 pairs were sent,
// the extra ones being ignored). All sums are exact integers and clear after each result.
// Every product goes through one 25 x 25 bit multiplier, one at a time: an ordinary pair
// stalls the input while its three products run; a pair beyond the limit runs none. The
// last pair then runs 17 more multiplier steps, a 33-step division and a 17-step square
// root in a shift-and-subtract unit. The result is offered once these finish, provided the
// output register is free. Inputs are taken again as soon as the result sits in the output
// register.
module pearson_correlation import pcorr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_sample_a,
    input  logic [15:0]        i_sample_b,
    input  logic               i_is_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_correlation,
    output logic [1:0]         o_status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_ROOT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state;
    logic [4:0]         r_step;
    logic [15:0]        r_a;
    logic [15:0]        r_b;
    logic               r_last;
    logic [8:0]         r_cnt;
    logic [23:0]        r_sa;
    logic [23:0]        r_sb;
    logic [39:0]        r_saa;
    logic [39:0]        r_sbb;
    logic [39:0]        r_sab;
    logic               r_ovf;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [MAG_W-1:0]   r_va;
    logic [MAG_W-1:0]   r_vb;
    logic [MAG_W-1:0]   r_cm;
    logic               r_va_ok;
    logic               r_vb_ok;
    logic               r_cneg;
    logic [WIDE_W-1:0]  r_p;
    logic [WIDE_W-1:0]  r_c2;
    logic               r_start;
    logic               r_ovalid;
    logic [15:0]        r_corr;
    logic [1:0]         r_stat;

    t_uop               uop;
    logic [LIMB_W-1:0]  op_x;
    logic [LIMB_W-1:0]  op_y;
    logic [ACC_W-1:0]   shifted;
    logic [ACC_W-1:0]   base;
    logic [ACC_W-1:0]   n_acc;
    logic               accept;
    logic [15:0]        a_m;
    logic [15:0]        b_m;
    logic               root_done;
    logic [ROOT_W-1:0]  root;
    logic [ROOT_W:0]    q_sum;
    logic [ROOT_W-1:0]  q;
    logic [15:0]        corr_val;
    logic [1:0]         stat_val;

    function automatic logic [LIMB_W-1:0] pick(input t_opnd s);
        logic [LIMB_W-1:0] v;
        case (s)
            OPD_A:     v = LIMB_W'(r_a);
            OPD_B:     v = LIMB_W'(r_b);
            OPD_N:     v = LIMB_W'(r_cnt);
            OPD_SA:    v = LIMB_W'(r_sa);
            OPD_SB:    v = LIMB_W'(r_sb);
            OPD_SAA_L: v = r_saa[LIMB_W-1:0];
            OPD_SAA_H: v = LIMB_W'(r_saa[39:LIMB_W]);
            OPD_SBB_L: v = r_sbb[LIMB_W-1:0];
            OPD_SBB_H: v = LIMB_W'(r_sbb[39:LIMB_W]);
            OPD_SAB_L: v = r_sab[LIMB_W-1:0];
            OPD_SAB_H: v = LIMB_W'(r_sab[39:LIMB_W]);
            OPD_VA_L:  v = r_va[LIMB_W-1:0];
            OPD_VA_H:  v = LIMB_W'(r_va[MAG_W-1:LIMB_W]);
            OPD_VB_L:  v = r_vb[LIMB_W-1:0];
            OPD_VB_H:  v = LIMB_W'(r_vb[MAG_W-1:LIMB_W]);
            OPD_CM_L:  v = r_cm[LIMB_W-1:0];
            OPD_CM_H:  v = LIMB_W'(r_cm[MAG_W-1:LIMB_W]);
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign a_m        = i_sample_a & SAMPLE_MASK;
    assign b_m        = i_sample_b & SAMPLE_MASK;

    always_comb begin
        uop  = f_uop(r_step);
        op_x = pick(uop.x);
        op_y = pick(uop.y);
        case (uop.sh)
            2'd1:    shifted = {{(ACC_W - PROD_W - LIMB_W){1'b0}}, r_prod, {LIMB_W{1'b0}}};
            2'd2:    shifted = {r_prod, {(ACC_W - PROD_W){1'b0}}};
            default: shifted = {{(ACC_W - PROD_W){1'b0}}, r_prod};
        endcase
        base  = uop.clr ? '0 : r_acc;
        n_acc = uop.sub ? base - shifted : base + shifted;
    end

    // Q is the largest value with (2Q-1)^2 * va * vb <= 2^32 * cov^2, i.e. (root + 1) / 2.
    always_comb begin
        q_sum = {1'b0, root} + (ROOT_W + 1)'(1);
        q     = q_sum[ROOT_W:1];
        if (!r_va_ok || !r_vb_ok) begin
            corr_val = '0;
        end else if (r_cneg) begin
            corr_val = 16'(-q);
        end else if (q > ROOT_W'(32767)) begin
            corr_val = 16'h7FFF;
        end else begin
            corr_val = q[15:0];
        end
        if (r_ovf) begin
            stat_val = ST_OVERFLOW;
        end else if (!r_va_ok || !r_vb_ok) begin
            stat_val = ST_ZERO_VAR;
        end else begin
            stat_val = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_cnt    <= '0;
            r_sa     <= '0;
            r_sb     <= '0;
            r_saa    <= '0;
            r_sbb    <= '0;
            r_sab    <= '0;
            r_ovf    <= 1'b0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a    <= a_m;
                        r_b    <= b_m;
                        r_last <= i_is_last;
                        if (r_cnt < MAX_CNT) begin
                            r_sa    <= r_sa + 24'(a_m);
                            r_sb    <= r_sb + 24'(b_m);
                            r_cnt   <= r_cnt + 9'd1;
                            r_step  <= STEP_PAIR_FIRST;
                            r_state <= S_MUL;
                        end else begin
                            r_ovf <= 1'b1;
                            if (i_is_last) begin
                                r_step  <= STEP_FINAL_FIRST;
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= op_x * op_y;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (uop.dst)
                        DST_SAA: r_saa <= r_saa + r_prod[39:0];
                        DST_SBB: r_sbb <= r_sbb + r_prod[39:0];
                        DST_SAB: r_sab <= r_sab + r_prod[39:0];
                        default: r_acc <= n_acc;
                    endcase
                    // The variance and covariance terms fit in 50 signed bits.
                    case (uop.cap)
                        CAP_VA: begin
                            r_va    <= n_acc[MAG_W-1:0];
                            r_va_ok <= !n_acc[MAG_W] && (n_acc[MAG_W:0] != '0);
                        end
                        CAP_VB: begin
                            r_vb    <= n_acc[MAG_W-1:0];
                            r_vb_ok <= !n_acc[MAG_W] && (n_acc[MAG_W:0] != '0);
                        end
                        CAP_CV: begin
                            r_cneg <= n_acc[MAG_W];
                            r_cm   <= n_acc[MAG_W] ? MAG_W'(-n_acc[MAG_W:0])
                                                   : n_acc[MAG_W-1:0];
                        end
                        CAP_P:   r_p  <= n_acc[WIDE_W-1:0];
                        CAP_C2:  r_c2 <= n_acc[WIDE_W-1:0];
                        default: ;
                    endcase
                    if (r_step == STEP_PAIR_LAST && !r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_step == STEP_FINAL_LAST) begin
                        r_start <= 1'b1;
                        r_state <= S_ROOT;
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= S_MUL;
                    end
                end
                S_ROOT: begin
                    if (root_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_corr   <= corr_val;
                        r_stat   <= stat_val;
                        r_cnt    <= '0;
                        r_sa     <= '0;
                        r_sb     <= '0;
                        r_saa    <= '0;
                        r_sbb    <= '0;
                        r_sab    <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pcorr_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_p     (r_p),
        .i_c2    (r_c2),
        .o_done  (root_done),
        .o_root  (root)
    );

    assign o_out_valid   = r_ovalid;
    assign o_correlation = r_corr;
    assign o_status      = r_stat;

endmodule

`default_nettype wire

### rtl/core/pcorr_checker.sv
// Port-level checks for the Pearson correlation block, bound to its top level.
// Depends on pcorr_pkg and pearson_correlation_macros.svh.
`default_nettype none
`include "pearson_correlation_macros.svh"

module pcorr_checker import pcorr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_correlation,
    input logic [1:0]         o_status
);

    // A stalled result beat stays offered and unchanged.
    `PCORR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_correlation) && $stable(o_status), "stalled result beat changed")

    `PCORR_ASSERT_SAME(a_status_code, o_out_valid, o_status == ST_OK || o_status == ST_ZERO_VAR || o_status == ST_OVERFLOW, "undefined status code")

    // A zero variance gives no coefficient.
    `PCORR_ASSERT_SAME(a_zero_var_corr, o_out_valid && o_status == ST_ZERO_VAR, o_correlation == 16'sd0, "non-zero coefficient with zero variance")

    // A result never appears straight after an input beat is taken.
    `PCORR_ASSERT_NEXT(a_no_instant_result, i_in_valid && !o_in_stall, !$rose(o_out_valid), "result offered one cycle after an input beat")

endmodule

bind pearson_correlation pcorr_checker u_pcorr_checker (.*);

`default_nettype wire
